// ----- hw/rtl/alpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Address lease pool allocator package
// Shared request and status codes and the controller/datapath command types.
// ----------------------------------------------------------------------------
package alpa_pkg;

    localparam logic [2:0] REQ_ACQUIRE = 3'd0;
    localparam logic [2:0] REQ_FIND    = 3'd1;
    localparam logic [2:0] REQ_RENEW   = 3'd2;
    localparam logic [2:0] REQ_OWNS    = 3'd3;
    localparam logic [2:0] REQ_RELEASE = 3'd4;
    localparam logic [2:0] REQ_REAP    = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISMATCH = 3'd1;
    localparam logic [2:0] ST_LEASED   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NO_IDS   = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    localparam logic [1:0] REG_POOL_FIRST = 2'd0;
    localparam logic [1:0] REG_POOL_LAST  = 2'd1;
    localparam logic [1:0] REG_LEASE_SECS = 2'd2;

    localparam int REQ_W = 3;
    localparam int ST_W  = 3;
    localparam int ID_W  = 32;
    localparam int ADR_W = 32;
    localparam int NOW_W = 40;
    localparam int EXP_W = 41;
    localparam int CNT_W = 9;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the request and clear the scan
        logic scan;    // visit the current slot
        logic commit;  // apply the update and build the result
    } alpa_cmd_t;

    // Status returned to the controller.
    typedef struct packed {
        logic scan_last; // current slot is the last one
        logic commit_rd; // pipelined read of the final slot has landed
    } alpa_sts_t;

endpackage

// ----- hw/rtl/alpa_if.sv -----
// ----------------------------------------------------------------------------
// Address lease pool allocator channel interfaces
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface alpa_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] client_tag;
    logic [31:0] expected_id;
    logic [31:0] ip_addr;
    logic [39:0] now_seconds;

    modport source (output valid, req_type, client_tag, expected_id, ip_addr,
                    now_seconds, input ready);
    modport sink (input valid, req_type, client_tag, expected_id, ip_addr,
                  now_seconds, output ready);
endinterface

interface alpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] lease_number;
    logic [31:0] leased_addr;
    logic [40:0] expiry_seconds;
    logic        owned;
    logic [8:0]  removed_count;
    logic [8:0]  active_leases;
    logic [8:0]  free_leases;

    modport source (output valid, status, lease_number, leased_addr,
                    expiry_seconds, owned, removed_count, active_leases,
                    free_leases, input ready);
    modport sink (input valid, status, lease_number, leased_addr,
                  expiry_seconds, owned, removed_count, active_leases,
                  free_leases, output ready);
endinterface

// ----- hw/rtl/alpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Address lease pool allocator controller
// Sequences load, slot scan, drain, commit and result handshake.
// ----------------------------------------------------------------------------
module alpa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  alpa_pkg::alpa_sts_t  sts,
    output alpa_pkg::alpa_cmd_t  cmd
);
    import alpa_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (sts.commit_rd)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/alpa_dp.sv -----
// ----------------------------------------------------------------------------
// Address lease pool allocator datapath
// Slot table memories, the reap and search scan, and the result registers.
// ----------------------------------------------------------------------------
module alpa_dp #(
    parameter int POOL_SLOTS = 256,
    parameter int TAG_BITS   = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  alpa_pkg::alpa_cmd_t  cmd,
    output alpa_pkg::alpa_sts_t  sts,
    input  logic [2:0]           req_type,
    input  logic [31:0]          client_tag,
    input  logic [31:0]          expected_id,
    input  logic [31:0]          ip_addr,
    input  logic [39:0]          now_seconds,
    input  logic [31:0]          pool_first,
    input  logic [31:0]          pool_last,
    input  logic [31:0]          lease_seconds,
    output logic [2:0]           status,
    output logic [31:0]          lease_number,
    output logic [31:0]          leased_addr,
    output logic [40:0]          expiry_seconds,
    output logic                 owned,
    output logic [8:0]           removed_count,
    output logic [8:0]           active_leases,
    output logic [8:0]           free_leases
);
    import alpa_pkg::*;

    localparam int IW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CW = $clog2(POOL_SLOTS + 1);
    localparam int TW = (TAG_BITS < 32) ? TAG_BITS : 32;

    logic              valid_reg [POOL_SLOTS];
    logic [TW-1:0]     client_mem [POOL_SLOTS];
    logic [ID_W-1:0]   id_mem [POOL_SLOTS];
    logic [EXP_W-1:0]  exp_mem [POOL_SLOTS];

    logic [REQ_W-1:0]  req_reg;
    logic [TW-1:0]     tag_reg;
    logic [ID_W-1:0]   eid_reg;
    logic [ADR_W-1:0]  addr_reg;
    logic [NOW_W-1:0]  now_reg;

    logic [IW-1:0]     idx_reg;
    logic              rd_v_reg;
    logic [IW-1:0]     rd_idx_reg;
    logic              rd_valid_reg;
    logic [TW-1:0]     rd_client_reg;
    logic [ID_W-1:0]   rd_id_reg;
    logic [EXP_W-1:0]  rd_exp_reg;

    logic              hit_reg;
    logic [IW-1:0]     hit_idx_reg;
    logic [ID_W-1:0]   hit_id_reg;
    logic [EXP_W-1:0]  hit_exp_reg;
    logic              free_found_reg;
    logic [IW-1:0]     free_idx_reg;
    logic [CW-1:0]     removed_reg;
    logic [CW-1:0]     active_reg;
    logic [ID_W-1:0]   next_id_reg;

    logic [2:0]        status_reg;
    logic [ID_W-1:0]   lease_reg;
    logic [ADR_W-1:0]  laddr_reg;
    logic [EXP_W-1:0]  lexp_reg;
    logic              owned_reg;
    logic [CW-1:0]     out_removed_reg;

    logic              do_reap;
    logic              rd_expired;
    logic              rd_live;
    logic [32:0]       span;
    logic [CW-1:0]     usable;
    logic [EXP_W-1:0]  new_exp;
    logic [ADR_W-1:0]  hit_addr;
    logic [ADR_W-1:0]  free_addr;
    logic              empty_acq;
    logic              wr_en;
    logic [IW-1:0]     wr_idx;
    logic              wr_valid;
    logic              match;

    assign do_reap    = (req_reg != REQ_RELEASE);
    assign empty_acq  = (req_reg == REQ_ACQUIRE) && (tag_reg == '0);
    assign rd_expired = rd_valid_reg && do_reap && !empty_acq
                        && (rd_exp_reg <= {1'b0, now_reg});
    assign rd_live    = rd_valid_reg && !rd_expired;

    always_comb
    begin
        span = {1'b0, pool_last} - {1'b0, pool_first} + 33'd1;
        if (pool_last < pool_first)
        begin
            usable = '0;
        end
        else if (span > 33'(POOL_SLOTS))
        begin
            usable = CW'(POOL_SLOTS);
        end
        else
        begin
            usable = CW'(span);
        end
    end

    assign new_exp   = {1'b0, now_reg} + {9'd0, lease_seconds};
    assign hit_addr  = pool_first + ADR_W'(hit_idx_reg);
    assign free_addr = pool_first + ADR_W'(free_idx_reg);
    assign match     = hit_reg && (tag_reg != '0);

    assign sts.scan_last = (idx_reg == IW'(POOL_SLOTS - 1));
    assign sts.commit_rd = rd_v_reg && (rd_idx_reg == IW'(POOL_SLOTS - 1));

    // Memory write port: expiry reaps during the scan, updates at commit.
    always_comb
    begin
        wr_en    = 1'b0;
        wr_idx   = rd_idx_reg;
        wr_valid = 1'b0;
        if (rd_v_reg && rd_expired)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.commit && !empty_acq)
        begin
            case (req_reg)
                REQ_ACQUIRE:
                begin
                    if (!match && free_found_reg && next_id_reg != '0)
                    begin
                        wr_en    = 1'b1;
                        wr_idx   = free_idx_reg;
                        wr_valid = 1'b1;
                    end
                end
                REQ_RENEW:
                begin
                    if (match && hit_id_reg == eid_reg && hit_addr == addr_reg)
                    begin
                        wr_en    = 1'b1;
                        wr_idx   = hit_idx_reg;
                        wr_valid = 1'b1;
                    end
                end
                REQ_RELEASE:
                begin
                    if (match && hit_id_reg == eid_reg && hit_addr == addr_reg)
                    begin
                        wr_en  = 1'b1;
                        wr_idx = hit_idx_reg;
                    end
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_SLOTS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (wr_en)
        begin
            valid_reg[wr_idx] <= wr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_en && wr_valid)
        begin
            exp_mem[wr_idx] <= new_exp;
            if (req_reg == REQ_ACQUIRE)
            begin
                client_mem[wr_idx] <= tag_reg;
                id_mem[wr_idx]     <= next_id_reg;
            end
        end
        rd_valid_reg  <= valid_reg[idx_reg];
        rd_client_reg <= client_mem[idx_reg];
        rd_id_reg     <= id_mem[idx_reg];
        rd_exp_reg    <= exp_mem[idx_reg];
        rd_idx_reg    <= idx_reg;
        if (cmd.load)
        begin
            req_reg  <= req_type;
            tag_reg  <= client_tag[TW-1:0];
            eid_reg  <= expected_id;
            addr_reg <= ip_addr;
            now_reg  <= now_seconds;
        end
        if (rd_v_reg && rd_live && rd_client_reg == tag_reg && !hit_reg)
        begin
            hit_idx_reg <= rd_idx_reg;
            hit_id_reg  <= rd_id_reg;
            hit_exp_reg <= rd_exp_reg;
        end
        if (rd_v_reg && !rd_live && !free_found_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            rd_v_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            removed_reg    <= '0;
            active_reg     <= '0;
            next_id_reg    <= ID_W'(1);
        end
        else
        begin
            rd_v_reg <= cmd.scan;
            if (cmd.load)
            begin
                idx_reg        <= '0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                removed_reg    <= '0;
            end
            else if (cmd.scan)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (rd_v_reg)
            begin
                if (rd_expired)
                begin
                    removed_reg <= removed_reg + CW'(1);
                    active_reg  <= active_reg - CW'(1);
                end
                if (rd_live && rd_client_reg == tag_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (!rd_live && !free_found_reg && CW'(rd_idx_reg) < usable)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.commit && wr_en)
            begin
                if (req_reg == REQ_ACQUIRE)
                begin
                    active_reg  <= active_reg + CW'(1);
                    next_id_reg <= next_id_reg + ID_W'(1);
                end
                else if (req_reg == REQ_RELEASE)
                begin
                    active_reg <= active_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg      <= ST_MISMATCH;
            lease_reg       <= '0;
            laddr_reg       <= '0;
            lexp_reg        <= '0;
            owned_reg       <= 1'b0;
            out_removed_reg <= removed_reg;
            if (empty_acq)
            begin
                status_reg <= ST_EMPTY;
            end
            else
            begin
                case (req_reg)
                    REQ_ACQUIRE:
                    begin
                        if (match)
                        begin
                            status_reg <= ST_LEASED;
                        end
                        else if (!free_found_reg)
                        begin
                            status_reg <= ST_FULL;
                        end
                        else if (next_id_reg == '0)
                        begin
                            status_reg <= ST_NO_IDS;
                        end
                        else
                        begin
                            status_reg <= ST_OK;
                            lease_reg  <= next_id_reg;
                            laddr_reg  <= free_addr;
                            lexp_reg   <= new_exp;
                        end
                    end
                    REQ_FIND:
                    begin
                        if (match)
                        begin
                            status_reg <= ST_OK;
                            lease_reg  <= hit_id_reg;
                            laddr_reg  <= hit_addr;
                            lexp_reg   <= hit_exp_reg;
                        end
                    end
                    REQ_RENEW, REQ_RELEASE:
                    begin
                        if (match && hit_id_reg == eid_reg && hit_addr == addr_reg)
                        begin
                            status_reg <= ST_OK;
                            lease_reg  <= hit_id_reg;
                            laddr_reg  <= hit_addr;
                            lexp_reg   <= (req_reg == REQ_RENEW) ? new_exp : hit_exp_reg;
                        end
                    end
                    REQ_OWNS:
                    begin
                        if (match && hit_addr == addr_reg)
                        begin
                            status_reg <= ST_OK;
                            owned_reg  <= 1'b1;
                            lease_reg  <= hit_id_reg;
                            laddr_reg  <= hit_addr;
                            lexp_reg   <= hit_exp_reg;
                        end
                    end
                    default:
                    begin
                        status_reg <= ST_OK;
                    end
                endcase
            end
        end
    end

    assign status         = status_reg;
    assign lease_number   = lease_reg;
    assign leased_addr    = laddr_reg;
    assign expiry_seconds = lexp_reg;
    assign owned          = owned_reg;
    assign removed_count  = CNT_W'(out_removed_reg);
    assign active_leases  = CNT_W'(active_reg);
    assign free_leases    = (usable > active_reg) ? CNT_W'(usable - active_reg) : '0;

endmodule

// ----- hw/rtl/alpa_cfg.sv -----
// ----------------------------------------------------------------------------
// Address lease pool allocator configuration registers
// APB-style register file for the pool bounds and lease duration.
// ----------------------------------------------------------------------------
module alpa_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] pool_first,
    output logic [31:0] pool_last,
    output logic [31:0] lease_seconds
);
    import alpa_pkg::*;

    logic [31:0] first_reg, last_reg, secs_reg;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 32'd167772162;
            last_reg  <= 32'd167772417;
            secs_reg  <= 32'd3600;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            case (paddr[3:2])
                REG_POOL_FIRST: first_reg <= pwdata;
                REG_POOL_LAST:  last_reg  <= pwdata;
                REG_LEASE_SECS: secs_reg  <= pwdata;
                default:        secs_reg  <= secs_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_POOL_FIRST: prdata = first_reg;
            REG_POOL_LAST:  prdata = last_reg;
            REG_LEASE_SECS: prdata = secs_reg;
            default:        prdata = '0;
        endcase
    end

    assign pool_first    = first_reg;
    assign pool_last     = last_reg;
    assign lease_seconds = secs_reg;

endmodule

// ----- hw/rtl/address_lease_pool_allocator.sv -----
// ----------------------------------------------------------------------------
// Address lease pool allocator
// Each request scans every slot of the lease table once, one slot per clock
// through a registered memory read, reaping expired leases (except on a
// release or an acquire with an empty tag), searching for the client tag and
// locating the lowest free slot; a commit state then updates the table. The
// result is presented once the single-port slot scan, the drain state and the
// commit state are done. The next request is accepted in the cycle after the
// result has been taken.
// ----------------------------------------------------------------------------
module address_lease_pool_allocator #(
    parameter int POOL_SLOTS = 256,
    parameter int TAG_BITS   = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    alpa_req_if.sink     req,
    alpa_rsp_if.source   rsp,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import alpa_pkg::*;

    alpa_cmd_t   cmd;
    alpa_sts_t   sts;
    logic [31:0] pool_first, pool_last, lease_seconds;

    alpa_cfg u_cfg (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .pool_first, .pool_last, .lease_seconds
    );

    alpa_ctrl u_ctrl (
        .clk, .rst_n,
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts, .cmd
    );

    alpa_dp #(.POOL_SLOTS(POOL_SLOTS), .TAG_BITS(TAG_BITS)) u_dp (
        .clk, .rst_n, .cmd, .sts,
        .req_type       (req.req_type),
        .client_tag     (req.client_tag),
        .expected_id    (req.expected_id),
        .ip_addr        (req.ip_addr),
        .now_seconds    (req.now_seconds),
        .pool_first, .pool_last, .lease_seconds,
        .status         (rsp.status),
        .lease_number   (rsp.lease_number),
        .leased_addr    (rsp.leased_addr),
        .expiry_seconds (rsp.expiry_seconds),
        .owned          (rsp.owned),
        .removed_count  (rsp.removed_count),
        .active_leases  (rsp.active_leases),
        .free_leases    (rsp.free_leases)
    );

endmodule
